### hdl/hcf_pkg.sv
package hcf_pkg;

    localparam int FRACTION_BITS = 8;
    localparam logic [8:0] FRAC_ONE = 9'd256;
    localparam logic [8:0] FRAC_HALF = 9'd128;

    // HSV values are Q.12: hue in half-degrees, S and V on 0..255
    localparam int HSV_BITS = 12;
    localparam int HSV_W = 20;

    localparam logic [HSV_W-1:0] SECTOR_Q = HSV_W'(30 << HSV_BITS);
    localparam logic [HSV_W-1:0] FULL_Q = HSV_W'(255 << HSV_BITS);
    localparam logic [12:0] HSV_ONE = 13'd4096;

    // x/30 = (x * RECIP_30) >> 22, exact for x < 30 * 4096
    localparam logic [17:0] RECIP_30 = 18'd139811;
    // x/255 = (x * RECIP_255) >> 24, exact for x < 65536
    localparam logic [16:0] RECIP_255 = 17'd65794;

    // hue sector base in half-degrees
    localparam logic [7:0] HUE_RED = 8'd0;
    localparam logic [7:0] HUE_GREEN = 8'd60;
    localparam logic [7:0] HUE_BLUE = 8'd120;
    localparam logic [7:0] HUE_WRAP = 8'd180;

    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } sector_t;

    typedef struct packed {
        logic [7:0] src_red;
        logic [7:0] src_green;
        logic [7:0] src_blue;
        logic [7:0] src_alpha;
        logic [7:0] dst_red;
        logic [7:0] dst_green;
        logic [7:0] dst_blue;
        logic [7:0] dst_alpha;
        logic [8:0] blend_fraction;
        logic       alpha_only;
    } req_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } res_t;

    typedef struct packed {
        logic [HSV_W-1:0] h;
        logic [HSV_W-1:0] s;
        logic [HSV_W-1:0] v;
    } hsv_t;

endpackage

### hdl/hcf_div.sv
// 28/8 restoring divider, 20 quotient bits, five bits per stage.
// Top eight numerator bits must be below the divisor.
module hcf_div (
    input  logic        clk,
    input  logic [3:0]  en,
    input  logic [27:0] num,
    input  logic [7:0]  den,
    output logic [19:0] quot
);

    typedef struct packed {
        logic [7:0]  rem;
        logic [19:0] nq;    // numerator bits shift out, quotient bits shift in
        logic [7:0]  den;
    } div_st_t;

    div_st_t seed;
    div_st_t st_reg  [4];
    div_st_t st_next [4];

    function automatic div_st_t div_steps(div_st_t cur);
        div_st_t    r;
        logic [8:0] t;
        r = cur;
        for (int i = 0; i < 5; i++) begin
            t = {r.rem, r.nq[19]};
            if (t >= {1'b0, r.den}) begin
                r.rem = 8'(t - {1'b0, r.den});
                r.nq  = {r.nq[18:0], 1'b1};
            end
            else begin
                r.rem = t[7:0];
                r.nq  = {r.nq[18:0], 1'b0};
            end
        end
        return r;
    endfunction

    always_comb
    begin
        seed.rem = num[27:20];
        seed.nq  = num[19:0];
        seed.den = den;
        st_next[0] = div_steps(seed);
        for (int k = 1; k < 4; k++) begin
            st_next[k] = div_steps(st_reg[k-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++) begin
            if (en[k])
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign quot = st_reg[3].nq;

endmodule

### hdl/hcf_rgb2hsv.sv
// RGB to HSV: min/max stage, four divider stages, hue assembly stage.
module hcf_rgb2hsv (
    input  logic          clk,
    input  logic [5:0]    en,
    input  logic [7:0]    red,
    input  logic [7:0]    green,
    input  logic [7:0]    blue,
    output hcf_pkg::hsv_t hsv
);

    typedef struct packed {
        logic       grey;
        logic       sub;
        logic [7:0] base;
        logic [7:0] mx;
    } hue_ctl_t;

    hue_ctl_t      ctl_next;
    hue_ctl_t      ctl_reg [5];
    logic [7:0]    mx;
    logic [7:0]    mn;
    logic [7:0]    dif;
    logic [7:0]    hx;
    logic [12:0]   hx30;
    logic [15:0]   d255;
    logic [27:0]   num_s_reg;
    logic [27:0]   num_h_reg;
    logic [7:0]    den_s_reg;
    logic [7:0]    den_h_reg;
    logic [19:0]   quot_s;
    logic [19:0]   quot_h;
    logic [19:0]   base_q;
    hcf_pkg::hsv_t hsv_reg;
    hcf_pkg::hsv_t hsv_next;

    always_comb
    begin
        mx = red;
        mn = red;
        if (green > mx) mx = green;
        if (blue > mx) mx = blue;
        if (green < mn) mn = green;
        if (blue < mn) mn = blue;
        dif = mx - mn;
        ctl_next.mx   = mx;
        ctl_next.grey = (mx == mn);
        // red wins ties, then green
        priority if (mx == red)
        begin
            if (green >= blue)
            begin
                hx = green - blue;
                ctl_next.base = hcf_pkg::HUE_RED;
                ctl_next.sub  = 1'b0;
            end
            else
            begin
                hx = blue - green;
                ctl_next.base = hcf_pkg::HUE_WRAP;
                ctl_next.sub  = 1'b1;
            end
        end
        else if (mx == green)
        begin
            ctl_next.base = hcf_pkg::HUE_GREEN;
            ctl_next.sub  = (blue < red);
            hx = (blue >= red) ? (blue - red) : (red - blue);
        end
        else
        begin
            ctl_next.base = hcf_pkg::HUE_BLUE;
            ctl_next.sub  = (red < green);
            hx = (red >= green) ? (red - green) : (green - red);
        end
        hx30 = 13'(hx) * 13'd30;
        d255 = 16'(dif) * 16'd255;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ctl_reg[0] <= ctl_next;
            num_s_reg  <= {d255, 12'b0};
            num_h_reg  <= {3'b0, hx30, 12'b0};
            den_s_reg  <= mx;
            den_h_reg  <= dif;
        end
        for (int k = 1; k < 5; k++) begin
            if (en[k])
            begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end
        if (en[5])
        begin
            hsv_reg <= hsv_next;
        end
    end

    hcf_div u_div_s (
        .clk  (clk),
        .en   (en[4:1]),
        .num  (num_s_reg),
        .den  (den_s_reg),
        .quot (quot_s)
    );

    hcf_div u_div_h (
        .clk  (clk),
        .en   (en[4:1]),
        .num  (num_h_reg),
        .den  (den_h_reg),
        .quot (quot_h)
    );

    always_comb
    begin
        base_q = {ctl_reg[4].base, 12'b0};
        hsv_next.v = {ctl_reg[4].mx, 12'b0};
        if (ctl_reg[4].grey)
        begin
            hsv_next.h = '0;
            hsv_next.s = '0;
        end
        else
        begin
            hsv_next.s = quot_s;
            hsv_next.h = ctl_reg[4].sub ? (base_q - quot_h) : (base_q + quot_h);
        end
    end

    assign hsv = hsv_reg;

endmodule

### hdl/hcf_hsv2rgb.sv
// HSV back to RGB over five stages: sector, fraction, p/q/t scale, value
// product, divide by 255 and channel select.
module hcf_hsv2rgb (
    input  logic          clk,
    input  logic [4:0]    en,
    input  hcf_pkg::hsv_t hsv,
    output logic [7:0]    red,
    output logic [7:0]    green,
    output logic [7:0]    blue
);

    hcf_pkg::sector_t sec_next;
    hcf_pkg::sector_t sec1_reg, sec2_reg, sec3_reg, sec4_reg;
    logic [16:0] rem_next;
    logic [16:0] rem1_reg;
    logic [19:0] s1_reg, s2_reg;
    logic [19:0] v1_reg, v2_reg, v3_reg;
    logic [34:0] frac_prod;
    logic [11:0] frac2_reg;
    logic [31:0] q_prod;
    logic [32:0] t_prod;
    logic [19:0] kp3_reg, kq3_reg, kt3_reg;
    logic [39:0] p_prod, qv_prod, tv_prod;
    logic [15:0] xp4_reg, xq4_reg, xt4_reg;
    logic [7:0]  cv4_reg;
    logic [32:0] yp, yq, yt;
    logic [7:0]  cp, cq, ct;
    logic [7:0]  red_reg, green_reg, blue_reg;
    logic [7:0]  red_next, green_next, blue_next;

    always_comb
    begin
        priority if (hsv.h >= 20'(5 * 30 * 4096))
        begin
            sec_next = hcf_pkg::SEC_5;
            rem_next = 17'(hsv.h - 20'(5 * 30 * 4096));
        end
        else if (hsv.h >= 20'(4 * 30 * 4096))
        begin
            sec_next = hcf_pkg::SEC_4;
            rem_next = 17'(hsv.h - 20'(4 * 30 * 4096));
        end
        else if (hsv.h >= 20'(3 * 30 * 4096))
        begin
            sec_next = hcf_pkg::SEC_3;
            rem_next = 17'(hsv.h - 20'(3 * 30 * 4096));
        end
        else if (hsv.h >= 20'(2 * 30 * 4096))
        begin
            sec_next = hcf_pkg::SEC_2;
            rem_next = 17'(hsv.h - 20'(2 * 30 * 4096));
        end
        else if (hsv.h >= hcf_pkg::SECTOR_Q)
        begin
            sec_next = hcf_pkg::SEC_1;
            rem_next = 17'(hsv.h - hcf_pkg::SECTOR_Q);
        end
        else
        begin
            sec_next = hcf_pkg::SEC_0;
            rem_next = 17'(hsv.h);
        end
    end

    assign frac_prod = 35'(rem1_reg) * 35'(hcf_pkg::RECIP_30);
    assign q_prod = 32'(s2_reg) * 32'(frac2_reg);
    assign t_prod = 33'(s2_reg) * 33'(hcf_pkg::HSV_ONE - 13'(frac2_reg));
    assign p_prod  = 40'(v3_reg) * 40'(hcf_pkg::FULL_Q - kp3_reg);
    assign qv_prod = 40'(v3_reg) * 40'(hcf_pkg::FULL_Q - kq3_reg);
    assign tv_prod = 40'(v3_reg) * 40'(hcf_pkg::FULL_Q - kt3_reg);
    assign yp = 33'(xp4_reg) * 33'(hcf_pkg::RECIP_255);
    assign yq = 33'(xq4_reg) * 33'(hcf_pkg::RECIP_255);
    assign yt = 33'(xt4_reg) * 33'(hcf_pkg::RECIP_255);
    assign cp = yp[31:24];
    assign cq = yq[31:24];
    assign ct = yt[31:24];

    always_comb
    begin
        unique case (sec4_reg)
            hcf_pkg::SEC_0:
            begin
                red_next = cv4_reg; green_next = ct; blue_next = cp;
            end
            hcf_pkg::SEC_1:
            begin
                red_next = cq; green_next = cv4_reg; blue_next = cp;
            end
            hcf_pkg::SEC_2:
            begin
                red_next = cp; green_next = cv4_reg; blue_next = ct;
            end
            hcf_pkg::SEC_3:
            begin
                red_next = cp; green_next = cq; blue_next = cv4_reg;
            end
            hcf_pkg::SEC_4:
            begin
                red_next = ct; green_next = cp; blue_next = cv4_reg;
            end
            default:
            begin
                red_next = cv4_reg; green_next = cp; blue_next = cq;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sec1_reg <= sec_next;
            rem1_reg <= rem_next;
            s1_reg   <= hsv.s;
            v1_reg   <= hsv.v;
        end
        if (en[1])
        begin
            sec2_reg  <= sec1_reg;
            frac2_reg <= frac_prod[33:22];
            s2_reg    <= s1_reg;
            v2_reg    <= v1_reg;
        end
        if (en[2])
        begin
            sec3_reg <= sec2_reg;
            kp3_reg  <= s2_reg;
            kq3_reg  <= q_prod[31:12];
            kt3_reg  <= t_prod[31:12];
            v3_reg   <= v2_reg;
        end
        if (en[3])
        begin
            sec4_reg <= sec3_reg;
            xp4_reg  <= p_prod[39:24];
            xq4_reg  <= qv_prod[39:24];
            xt4_reg  <= tv_prod[39:24];
            cv4_reg  <= v3_reg[19:12];
        end
        if (en[4])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

### hdl/hsv_color_fade.sv
// channel | direction | payload
// req     | in        | req_data: source/target RGBA, blend fraction, alpha-only flag
// res     | out       | res_data: faded RGBA
// cfg     | in        | cfg_data: alpha scale, always ready
//
// Twelve register stages; one request enters per clock while the output is not stalled.
// The 20-bit quotient dividers take four of the stages, five bits each.
// Each stage advances when empty or when the stage after it advances, so a
// stalled output holds its result while bubbles upstream still fill.
// rst_n clears the stage valid bits and sets the alpha scale to 255.
module hsv_color_fade (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  hcf_pkg::req_t  req_data,
    output logic           res_valid,
    input  logic           res_ready,
    output hcf_pkg::res_t  res_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [7:0]     cfg_data
);

    localparam int STAGES = 12;
    localparam int HSV_STAGE = 5;
    localparam int BLEND_STAGE = 6;

    typedef struct packed {
        logic [15:0] alpha;
        logic        only;
        logic [7:0]  sr;
        logic [7:0]  sg;
        logic [7:0]  sb;
        logic [8:0]  frac;
    } side_t;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES:0]   en;
    logic [7:0]        alpha_scale_reg;
    side_t             side_reg  [STAGES];
    side_t             side_next [STAGES];
    logic [8:0]        f_in;
    logic [16:0]       a_sum;
    logic [32:0]       a_div;
    hcf_pkg::hsv_t     hsv_src;
    hcf_pkg::hsv_t     hsv_dst;
    hcf_pkg::hsv_t     hsv_blend_reg;
    hcf_pkg::hsv_t     hsv_blend_next;
    logic [7:0]        fade_red, fade_green, fade_blue;

    function automatic logic [19:0] blend(logic [8:0] f, logic [19:0] a, logic [19:0] b);
        logic [29:0] sum;
        sum = 30'(hcf_pkg::FRAC_ONE - f) * 30'(a) + 30'(f) * 30'(b);
        return 20'(sum >> hcf_pkg::FRACTION_BITS);
    endfunction

    always_comb
    begin
        en[STAGES] = res_ready;
        for (int i = STAGES - 1; i >= 0; i--) begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign req_ready  = en[0];
    assign res_valid  = valid_reg[STAGES-1];
    assign cfg_ready  = 1'b1;
    assign valid_next = {valid_reg[STAGES-2:0], req_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            alpha_scale_reg <= 8'd255;
        end
        else
        begin
            for (int i = 0; i < STAGES; i++) begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_next[i];
                end
            end
            if (cfg_valid)
            begin
                alpha_scale_reg <= cfg_data;
            end
        end
    end

    // side data: alpha blend, alpha scale, divide by 255, then carried
    always_comb
    begin
        f_in = (req_data.blend_fraction > hcf_pkg::FRAC_ONE) ? hcf_pkg::FRAC_ONE
                                                             : req_data.blend_fraction;
        a_sum = 17'(hcf_pkg::FRAC_ONE - f_in) * 17'(req_data.src_alpha)
              + 17'(f_in) * 17'(req_data.dst_alpha) + 17'(hcf_pkg::FRAC_HALF);
        side_next[0].frac  = f_in;
        side_next[0].only  = req_data.alpha_only;
        side_next[0].sr    = req_data.src_red;
        side_next[0].sg    = req_data.src_green;
        side_next[0].sb    = req_data.src_blue;
        side_next[0].alpha = (a_sum[16:8] > 9'd255) ? 16'd255 : 16'(a_sum[16:8]);
        for (int i = 1; i < STAGES; i++) begin
            side_next[i] = side_reg[i-1];
        end
        side_next[1].alpha = 16'(side_reg[0].alpha[7:0]) * 16'(alpha_scale_reg);
        a_div = 33'(side_reg[1].alpha) * 33'(hcf_pkg::RECIP_255);
        side_next[2].alpha = 16'(a_div[31:24]);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STAGES; i++) begin
            if (en[i])
            begin
                side_reg[i] <= side_next[i];
            end
        end
        if (en[BLEND_STAGE])
        begin
            hsv_blend_reg <= hsv_blend_next;
        end
    end

    hcf_rgb2hsv u_src_hsv (
        .clk   (clk),
        .en    (en[HSV_STAGE:0]),
        .red   (req_data.src_red),
        .green (req_data.src_green),
        .blue  (req_data.src_blue),
        .hsv   (hsv_src)
    );

    hcf_rgb2hsv u_dst_hsv (
        .clk   (clk),
        .en    (en[HSV_STAGE:0]),
        .red   (req_data.dst_red),
        .green (req_data.dst_green),
        .blue  (req_data.dst_blue),
        .hsv   (hsv_dst)
    );

    // no hue wraparound: plain linear blend
    always_comb
    begin
        hsv_blend_next.h = blend(side_reg[HSV_STAGE].frac, hsv_src.h, hsv_dst.h);
        hsv_blend_next.s = blend(side_reg[HSV_STAGE].frac, hsv_src.s, hsv_dst.s);
        hsv_blend_next.v = blend(side_reg[HSV_STAGE].frac, hsv_src.v, hsv_dst.v);
    end

    hcf_hsv2rgb u_rgb (
        .clk   (clk),
        .en    (en[STAGES-1:BLEND_STAGE+1]),
        .hsv   (hsv_blend_reg),
        .red   (fade_red),
        .green (fade_green),
        .blue  (fade_blue)
    );

    always_comb
    begin
        res_data.out_alpha = side_reg[STAGES-1].alpha[7:0];
        if (side_reg[STAGES-1].only)
        begin
            res_data.out_red   = side_reg[STAGES-1].sr;
            res_data.out_green = side_reg[STAGES-1].sg;
            res_data.out_blue  = side_reg[STAGES-1].sb;
        end
        else
        begin
            res_data.out_red   = fade_red;
            res_data.out_green = fade_green;
            res_data.out_blue  = fade_blue;
        end
    end

endmodule
